[rtl/wpmd_pkg.sv]
// ----------------------------------------------------------------------------
// wpmd_pkg: shared types and constants for the wav pcm mono downmix block
// sample modes, status codes, register indexes, sequencer states and helpers
// ----------------------------------------------------------------------------
package wpmd_pkg;

  // widths
  localparam int SUM_W       = 35;  // signed q4.30 frame sum of q1.30 samples, up to eight channels
  localparam int MAG_W       = 34;  // magnitude of the frame sum
  localparam int DIV_STEPS   = MAG_W;
  localparam int DIV_CNT_W   = 6;
  localparam int CNT_W       = 4;   // channel_count register
  localparam int MODE_W      = 3;   // sample_mode register
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CNT_W-1:0] MAX_CHANNELS = 4'd8;
  localparam logic [30:0]      Q_ONE        = 31'h4000_0000;

  // sample modes
  localparam logic [MODE_W-1:0] MODE_U8  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_S16 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_S24 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_S32 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_F32 = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD     = 2'd1;
  localparam logic [1:0] STATUS_PARTIAL = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_MODE   = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_ACCUM,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [2:0] bytes_per_sample(input logic [MODE_W-1:0] mode);
    logic [2:0] bps;
    case (mode)
      MODE_S16: bps = 3'd2;
      MODE_S24: bps = 3'd3;
      MODE_S32: bps = 3'd4;
      MODE_F32: bps = 3'd4;
      default:  bps = 3'd1;
    endcase
    return bps;
  endfunction

  function automatic logic [CNT_W-1:0] active_channels(input logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] act;
    if (count == '0) begin
      act = 4'd1;
    end else if (count > MAX_CHANNELS) begin
      act = MAX_CHANNELS;
    end else begin
      act = count;
    end
    return act;
  endfunction

endpackage

[rtl/wav_pcm_to_mono_downmix_top.sv]
// ----------------------------------------------------------------------------
// wav_pcm_to_mono_downmix_top: wav sample byte decoder with mono downmix
// assembles little-endian samples, averages each frame, emits q1.30 items
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one raw sample byte per item (s_tdata), s_tlast on the final
//   byte of a buffer. m_* channel: one item per completed frame, or one item
//   when s_tlast cuts a frame short. m_tdata is the q1.30 mean, m_tuser the
//   status (ok, bad sample in frame, partial frame), m_tlast closes the buffer.
//   cfg_we/cfg_index/cfg_data write channel_count (index 0) and sample_mode
//   (index 1); write them only while no item is in flight.
// timing
//   a byte that does not finish a sample passes the idle and step states; one
//   that ends a sample but not a frame adds the accum state, and one that ends
//   a good frame goes on through div to emit, which loads the output register.
//   the mean comes from one restoring divider that retires one quotient bit per
//   cycle over the 34-bit sum magnitude. s_tready is high only while idle.
// reset
//   rst clears the frame state and sets channel_count 1, sample_mode s16.
// stall
//   the output register holds its item until m_tready; new bytes are still
//   taken meanwhile, and the sequencer waits in its emit step only if the next
//   result is ready before the previous one has left.
// ----------------------------------------------------------------------------
module wav_pcm_to_mono_downmix_top (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  logic                               s_tlast,   // last_byte
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [31:0]                        m_tdata,   // [31:0] mono_sample
  output logic [1:0]                         m_tuser,   // [1:0] status
  output logic                               m_tlast,   // end_of_buffer
  // configuration
  input  logic                               cfg_we,
  input  logic [wpmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wpmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [wpmd_pkg::CNT_W-1:0]  channel_count;
  logic [wpmd_pkg::MODE_W-1:0] sample_mode;

  // sequencer
  wpmd_pkg::state_t state, state_next;

  // frame state
  logic [1:0]                 byte_position, byte_position_next;
  logic [2:0]                 channel_position, channel_position_next;
  logic [23:0]                sample_bytes, sample_bytes_next;
  logic [wpmd_pkg::SUM_W-1:0] channel_sum, channel_sum_next;
  logic                       bad_seen, bad_seen_next;

  // captured item and assembled sample
  logic [7:0]  in_byte;
  logic        in_last;
  logic [31:0] raw, raw_next;

  // divider and pending result
  logic [wpmd_pkg::MAG_W-1:0]     quo, quo_next;
  logic [3:0]                     rem, rem_next;
  logic [wpmd_pkg::DIV_CNT_W-1:0] div_count, div_count_next;
  logic                           neg, neg_next;
  logic [1:0]                     res_status, res_status_next;

  // output register
  logic        m_tvalid_next;
  logic [31:0] m_tdata_next;
  logic [1:0]  m_tuser_next;
  logic        m_tlast_next;

  // helpers
  logic [2:0]                 bps;
  logic [wpmd_pkg::CNT_W-1:0] active;
  logic                       sample_done;
  logic                       frame_done;
  logic                       out_free;
  logic [31:0]                shifted_byte;
  logic [31:0]                q;
  logic                       q_bad;
  logic [wpmd_pkg::SUM_W-1:0] sum_now;
  logic [wpmd_pkg::SUM_W-1:0] sum_abs;
  logic                       bad_now;
  logic [4:0]                 rem_sh;
  logic [4:0]                 divisor;
  logic                       div_ge;
  logic [30:0]                mean_mag;
  logic [31:0]                mean_val;

  // float decode pieces
  logic [7:0]  f_exp;
  logic [23:0] f_full;
  logic [7:0]  f_rsh;
  logic [30:0] f_mag;

  assign bps          = wpmd_pkg::bytes_per_sample(sample_mode);
  assign active       = wpmd_pkg::active_channels(channel_count);
  assign sample_done  = !(({1'b0, byte_position} + 3'd1) < bps);
  assign frame_done   = ({1'b0, channel_position} + 4'd1) >= active;
  assign out_free     = !m_tvalid || m_tready;
  assign shifted_byte = {24'd0, in_byte} << {byte_position, 3'b000};
  assign s_tready     = (state == wpmd_pkg::ST_IDLE);

  // float32 magnitude in q1.30, clamped to one
  always_comb begin
    f_exp  = raw[30:23];
    f_full = {1'b1, raw[22:0]};
    f_rsh  = 8'd120 - f_exp;
    if (f_exp == 8'd0) begin
      f_mag = '0;
    end else if (f_exp >= 8'd127) begin
      f_mag = wpmd_pkg::Q_ONE;
    end else if (f_exp >= 8'd120) begin
      f_mag = {7'd0, f_full} << f_exp[2:0];   // exponent 120..126 maps to shift 0..6
    end else if (f_rsh >= 8'd32) begin
      f_mag = '0;
    end else begin
      f_mag = {7'd0, f_full >> f_rsh[4:0]};
    end
  end

  // sample decode to q1.30
  always_comb begin
    q_bad = 1'b0;
    case (sample_mode)
      wpmd_pkg::MODE_U8:  q = {~raw[7], ~raw[7], raw[6:0], 23'd0};
      wpmd_pkg::MODE_S16: q = {raw[15], raw[15:0], 15'd0};
      wpmd_pkg::MODE_S24: q = {raw[23], raw[23:0], 7'd0};
      wpmd_pkg::MODE_S32: q = {raw[31], raw[31:1]};   // floor of half
      wpmd_pkg::MODE_F32: begin
        q_bad = (f_exp == 8'hFF);
        q     = raw[31] ? (32'd0 - {1'b0, f_mag}) : {1'b0, f_mag};
      end
      default: begin
        q_bad = 1'b1;
        q     = '0;
      end
    endcase
  end

  assign sum_now = channel_sum + {{3{q[31]}}, q};
  assign sum_abs = sum_now[wpmd_pkg::SUM_W-1] ? (35'd0 - sum_now) : sum_now;
  assign bad_now = bad_seen || q_bad;

  // one quotient bit per cycle
  assign rem_sh  = {rem, quo[wpmd_pkg::MAG_W-1]};
  assign divisor = {1'b0, active};
  assign div_ge  = rem_sh >= divisor;

  // clamp the quotient magnitude, then apply the sign
  assign mean_mag = (quo > {3'd0, wpmd_pkg::Q_ONE}) ? wpmd_pkg::Q_ONE : quo[30:0];
  assign mean_val = neg ? (32'd0 - {1'b0, mean_mag}) : {1'b0, mean_mag};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wpmd_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = wpmd_pkg::ST_STEP;
      end
      wpmd_pkg::ST_STEP: begin
        if (sample_done) begin
          state_next = wpmd_pkg::ST_ACCUM;
        end else if (in_last) begin
          state_next = wpmd_pkg::ST_EMIT;
        end else begin
          state_next = wpmd_pkg::ST_IDLE;
        end
      end
      wpmd_pkg::ST_ACCUM: begin
        if (frame_done) begin
          state_next = bad_now ? wpmd_pkg::ST_EMIT : wpmd_pkg::ST_DIV;
        end else if (in_last) begin
          state_next = wpmd_pkg::ST_EMIT;
        end else begin
          state_next = wpmd_pkg::ST_IDLE;
        end
      end
      wpmd_pkg::ST_DIV: begin
        if (div_count == wpmd_pkg::DIV_CNT_W'(wpmd_pkg::DIV_STEPS - 1)) begin
          state_next = wpmd_pkg::ST_EMIT;
        end
      end
      wpmd_pkg::ST_EMIT: begin
        if (out_free) state_next = wpmd_pkg::ST_IDLE;
      end
      default: state_next = wpmd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    byte_position_next    = byte_position;
    channel_position_next = channel_position;
    sample_bytes_next     = sample_bytes;
    channel_sum_next      = channel_sum;
    bad_seen_next         = bad_seen;
    raw_next              = raw;
    quo_next              = quo;
    rem_next              = rem;
    div_count_next        = div_count;
    neg_next              = neg;
    res_status_next       = res_status;
    m_tvalid_next         = m_tvalid && !m_tready;
    m_tdata_next          = m_tdata;
    m_tuser_next          = m_tuser;
    m_tlast_next          = m_tlast;

    case (state)
      wpmd_pkg::ST_STEP: begin
        if (sample_done) begin
          raw_next           = {8'd0, sample_bytes} | shifted_byte;
          byte_position_next = '0;
          sample_bytes_next  = '0;
        end else begin
          sample_bytes_next  = sample_bytes | shifted_byte[23:0];
          byte_position_next = byte_position + 2'd1;
          res_status_next    = wpmd_pkg::STATUS_PARTIAL;
        end
      end
      wpmd_pkg::ST_ACCUM: begin
        if (!q_bad) channel_sum_next = sum_now;
        bad_seen_next = bad_now;
        if (frame_done) begin
          res_status_next = bad_now ? wpmd_pkg::STATUS_BAD : wpmd_pkg::STATUS_OK;
          quo_next        = sum_abs[wpmd_pkg::MAG_W-1:0];
          neg_next        = sum_now[wpmd_pkg::SUM_W-1];
          rem_next        = '0;
          div_count_next  = '0;
        end else begin
          channel_position_next = channel_position + 3'd1;
          res_status_next       = wpmd_pkg::STATUS_PARTIAL;
        end
      end
      wpmd_pkg::ST_DIV: begin
        rem_next       = div_ge ? 4'(rem_sh - divisor) : rem_sh[3:0];
        quo_next       = {quo[wpmd_pkg::MAG_W-2:0], div_ge};
        div_count_next = div_count + wpmd_pkg::DIV_CNT_W'(1);
      end
      wpmd_pkg::ST_EMIT: begin
        if (out_free) begin
          m_tvalid_next         = 1'b1;
          m_tdata_next          = (res_status == wpmd_pkg::STATUS_OK) ? mean_val : '0;
          m_tuser_next          = res_status;
          m_tlast_next          = in_last;
          byte_position_next    = '0;
          channel_position_next = '0;
          sample_bytes_next     = '0;
          channel_sum_next      = '0;
          bad_seen_next         = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= wpmd_pkg::ST_IDLE;
      channel_count    <= 4'd1;
      sample_mode      <= wpmd_pkg::MODE_S16;
      byte_position    <= '0;
      channel_position <= '0;
      sample_bytes     <= '0;
      channel_sum      <= '0;
      bad_seen         <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      state            <= state_next;
      byte_position    <= byte_position_next;
      channel_position <= channel_position_next;
      sample_bytes     <= sample_bytes_next;
      channel_sum      <= channel_sum_next;
      bad_seen         <= bad_seen_next;
      m_tvalid         <= m_tvalid_next;
      if (cfg_we) begin
        case (cfg_index)
          wpmd_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[wpmd_pkg::CNT_W-1:0];
          wpmd_pkg::REG_SAMPLE_MODE:   sample_mode   <= cfg_data[wpmd_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    raw        <= raw_next;
    quo        <= quo_next;
    rem        <= rem_next;
    div_count  <= div_count_next;
    neg        <= neg_next;
    res_status <= res_status_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
    m_tlast    <= m_tlast_next;
  end

  // a cut-short frame always reads zero and closes the buffer
  a_partial_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == wpmd_pkg::STATUS_PARTIAL) |-> (m_tdata == '0 && m_tlast))
    else $error("partial frame result not zero or not closing the buffer");

  // the mean stays inside the clamp range
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= 32'sh4000_0000 && $signed(m_tdata) >= -32'sh4000_0000))
    else $error("mono sample outside q1.30 clamp range");

  // loading a result leaves a clean frame
  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == wpmd_pkg::ST_EMIT && out_free) |=>
      (channel_sum == '0 && byte_position == '0 && channel_position == '0 && !bad_seen))
    else $error("frame state not cleared after result");

  // divider never runs past its last quotient bit
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == wpmd_pkg::ST_DIV) |-> (div_count < wpmd_pkg::DIV_CNT_W'(wpmd_pkg::DIV_STEPS)))
    else $error("divider step count overrun");

endmodule

[bench/wav_pcm_to_mono_downmix_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm_to_mono_downmix_top_test: self-checking bench for the mono downmix
// feeds sample bytes in every sample mode and channel count, keeps a
// behavioral copy of the decoder and checks every result item field by field
// ----------------------------------------------------------------------------
module wav_pcm_to_mono_downmix_top_test;

  localparam int HALF_PERIOD_NS  = 6;
  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 60;    // longer than a frame takes through the divider
  localparam int END_CYCLES      = 100;
  localparam int STALL_LIMIT     = 5000;  // cycles without any accepted item
  localparam int RANDOM_ITEMS    = 630;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int BUFFER_BYTES    = 48;    // rough size of one random buffer

  localparam longint Q30_ONE = 64'sd1073741824;

  // modes the block does not define, each one byte wide and always bad
  localparam logic [wpmd_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [wpmd_pkg::MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [31:0] mono_sample;
    logic [1:0]  status;
    logic        end_of_buffer;
  } mono_result_t;

  // receiver stall styles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_CHUNKS
  } rx_style_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [7:0]                       s_tdata;   // [7:0] data_byte
  logic                             s_tlast;   // last_byte
  logic                             m_tvalid;
  logic                             m_tready;
  logic [31:0]                      m_tdata;   // [31:0] mono_sample
  logic [1:0]                       m_tuser;   // [1:0] status
  logic                             m_tlast;   // end_of_buffer
  logic                             cfg_we;
  logic [wpmd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [wpmd_pkg::CFG_DATA_W-1:0]  cfg_data;

  // shadow of the block: registers and frame state
  logic [wpmd_pkg::CNT_W-1:0]  cfg_channels;
  logic [wpmd_pkg::MODE_W-1:0] cfg_mode;
  int                          acc_byte_idx;
  int                          acc_chan_idx;
  logic [23:0]                 acc_bytes;
  longint                      acc_sum;
  bit                          acc_bad;

  mono_result_t pending_means[$];   // expected result items, oldest first

  int mismatch_count = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  // sender burst control
  bit sender_gaps_on = 1'b1;
  int burst_left     = 0;

  // receiver control, the hold-off is counted in the receiver process
  int        hold_request = 0;
  rx_style_t rx_style     = RX_OPEN;
  int        rx_style_left = 0;
  int        rx_tick      = 0;
  int        rx_chunk_left = 0;
  logic      rx_chunk_ready = 1'b1;

  wav_pcm_to_mono_downmix_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD_NS clk = ~clk;

  // ------------------------------------------------------------------------
  // behavioral decoder
  // ------------------------------------------------------------------------

  function automatic int mode_bytes(input logic [wpmd_pkg::MODE_W-1:0] mode);
    case (mode)
      wpmd_pkg::MODE_S16: return 2;
      wpmd_pkg::MODE_S24: return 3;
      wpmd_pkg::MODE_S32, wpmd_pkg::MODE_F32: return 4;
      default: return 1;
    endcase
  endfunction

  // channel count register as the block uses it: zero means one, clipped at max
  function automatic int frame_channels(input logic [wpmd_pkg::CNT_W-1:0] count);
    if (count == 4'd0) return 1;
    if (count > wpmd_pkg::MAX_CHANNELS) return int'(wpmd_pkg::MAX_CHANNELS);
    return int'(count);
  endfunction

  function automatic void clear_frame_model();
    acc_byte_idx = 0;
    acc_chan_idx = 0;
    acc_bytes    = '0;
    acc_sum      = 0;
    acc_bad      = 1'b0;
  endfunction

  function automatic void reset_model();
    cfg_channels = 4'd1;
    cfg_mode     = wpmd_pkg::MODE_S16;
    clear_frame_model();
  endfunction

  // one assembled sample to q1.30, returns 0 for a sample that poisons the frame
  function automatic logic sample_to_q30(input logic [31:0] raw,
                                         input logic [wpmd_pkg::MODE_W-1:0] mode,
                                         output longint q);
    int     ex;
    longint frac;
    longint mag;
    logic   good;
    good = 1'b1;
    q    = 0;
    case (mode)
      wpmd_pkg::MODE_U8:  q = (longint'(raw[7:0]) - 128) * 8388608;
      wpmd_pkg::MODE_S16: q = longint'($signed(raw[15:0])) * 32768;
      wpmd_pkg::MODE_S24: q = longint'($signed(raw[23:0])) * 128;
      wpmd_pkg::MODE_S32: q = (longint'($signed(raw)) - longint'(raw[0])) / 2;
      wpmd_pkg::MODE_F32: begin
        ex   = raw[30:23];
        frac = {1'b1, raw[22:0]};
        if (ex == 255) begin
          // infinity or nan
          good = 1'b0;
        end else begin
          // exponent 127 is 1.0, anything at or above clamps to one
          if (ex == 0) begin
            mag = 0;
          end else if (ex >= 127) begin
            mag = Q30_ONE;
          end else if (ex >= 120) begin
            mag = frac << (ex - 120);
          end else if (120 - ex >= 32) begin
            mag = 0;
          end else begin
            mag = frac >> (120 - ex);
          end
          q = raw[31] ? -mag : mag;
        end
      end
      default: good = 1'b0;
    endcase
    return good;
  endfunction

  // takes one accepted byte and queues the result item it causes, if any
  function automatic void downmix_byte(input logic [7:0] b, input logic last);
    int           nbytes;
    int           nchan;
    logic [31:0]  raw;
    longint       q;
    longint       mean;
    bit           done;
    mono_result_t r;
    nbytes = mode_bytes(cfg_mode);
    nchan  = frame_channels(cfg_channels);
    done   = 1'b0;
    if (acc_byte_idx + 1 < nbytes) begin
      acc_bytes    = acc_bytes | (24'(b) << (8 * acc_byte_idx));
      acc_byte_idx = (acc_byte_idx + 1) % 4;
    end else begin
      // sample complete, even if the width shrank mid-sample
      raw = {8'd0, acc_bytes} | (32'(b) << (8 * acc_byte_idx));
      if (sample_to_q30(raw, cfg_mode, q)) begin
        acc_sum += q;
      end else begin
        acc_bad = 1'b1;
      end
      acc_byte_idx = 0;
      acc_bytes    = '0;
      if (acc_chan_idx + 1 >= nchan) begin
        done = 1'b1;
      end else begin
        acc_chan_idx = (acc_chan_idx + 1) % 8;
      end
    end

    if (done) begin
      mean = acc_sum / longint'(nchan);   // truncates toward zero
      if (mean > Q30_ONE) mean = Q30_ONE;
      if (mean < -Q30_ONE) mean = -Q30_ONE;
      r.status = wpmd_pkg::STATUS_OK;
      if (acc_bad) begin
        mean     = 0;
        r.status = wpmd_pkg::STATUS_BAD;
      end
      r.mono_sample   = mean[31:0];
      r.end_of_buffer = last;
      pending_means.push_back(r);
      clear_frame_model();
    end else if (last) begin
      // buffer closed inside a frame
      r.mono_sample   = '0;
      r.status        = wpmd_pkg::STATUS_PARTIAL;
      r.end_of_buffer = 1'b1;
      pending_means.push_back(r);
      clear_frame_model();
    end
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // float32 values spread over the interesting exponent bands
  function automatic logic [31:0] random_float();
    logic [7:0] ex;
    case ($urandom_range(0, 9))
      0: ex = 8'hFF;                             // inf or nan
      1: ex = 8'h00;                             // zero or subnormal
      2: ex = 8'($urandom_range(127, 254));      // clamps to one
      3: ex = 8'($urandom_range(120, 126));      // shifted left
      4: ex = 8'($urandom_range(1, 119));        // shifted right, maybe to zero
      5: return {1'($urandom_range(0, 1)), 8'd127, 23'd0};   // exactly one
      default: ex = 8'($urandom_range(100, 126));
    endcase
    return {1'($urandom_range(0, 1)), ex, 23'($urandom)};
  endfunction

  function automatic logic [31:0] random_pcm();
    if ($urandom_range(0, 4) != 0) return $urandom;
    // extremes of the narrow and wide formats
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0080_8000;
      default: return 32'h007F_7FFF;
    endcase
  endfunction

  function automatic logic [31:0] sample_for_mode(input logic [wpmd_pkg::MODE_W-1:0] mode);
    if (mode == wpmd_pkg::MODE_F32) return random_float();
    return random_pcm();
  endfunction

  function automatic logic [wpmd_pkg::CFG_DATA_W-1:0] pick_channels();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2: return wpmd_pkg::MAX_CHANNELS;
      3: return 4'd1;
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  // the unused top data bit is set now and then, the register keeps three bits
  function automatic logic [wpmd_pkg::CFG_DATA_W-1:0] pick_mode();
    logic [wpmd_pkg::MODE_W-1:0] mode;
    if ($urandom_range(0, 19) < 18) begin
      mode = wpmd_pkg::MODE_W'($urandom_range(wpmd_pkg::MODE_U8, wpmd_pkg::MODE_F32));
    end else begin
      mode = wpmd_pkg::MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    end
    return {1'($urandom_range(0, 7) == 0), mode};
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(input logic [wpmd_pkg::CFG_INDEX_W-1:0] index,
                           input logic [wpmd_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (index == wpmd_pkg::REG_CHANNEL_COUNT) begin
      cfg_channels = value[wpmd_pkg::CNT_W-1:0];
    end else begin
      cfg_mode = value[wpmd_pkg::MODE_W-1:0];
    end
  endtask

  // holds one byte on the input until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    downmix_byte(b, last);
  endtask

  // bursts of random length with random gaps in between
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    if (sender_gaps_on && burst_left <= 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(10, 60);
      end else begin
        gap = $urandom_range(0, 4);
      end
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(50, 150);   // a stretch with no idling
      end else begin
        burst_left = $urandom_range(1, 20);
      end
    end
    burst_left--;
    send_byte(b, last);
  endtask

  // one sample, little-endian, last mark on its final byte if asked
  task automatic send_sample(input logic [31:0] raw, input int nbytes,
                             input logic last);
    for (int k = 0; k < nbytes; k++) begin
      send_item(raw[8*k +: 8], last && (k == nbytes - 1));
    end
  endtask

  // lowers valid, waits for every expected item, then lets the block go quiet
  task automatic drain_results(input int extra_cycles);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // whole frames of random content, optionally cut short by an early last mark
  task automatic run_buffer(input int frames, input bit broken);
    int          nbytes;
    int          total;
    int          cut;
    logic [31:0] raw;
    nbytes = mode_bytes(cfg_mode);
    total  = frames * frame_channels(cfg_channels) * nbytes;
    cut    = broken ? $urandom_range(0, total - 1) : total - 1;
    raw    = '0;
    for (int idx = 0; idx <= cut; idx++) begin
      if (idx % nbytes == 0) raw = sample_for_mode(cfg_mode);
      send_item(raw[8*(idx % nbytes) +: 8], idx == cut);
    end
  endtask

  // a frame left open while a register changes underneath it
  task automatic run_unfinished();
    repeat ($urandom_range(1, 7)) send_item(8'($urandom), 1'b0);
    drain_results(SETTLE_CYCLES);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(wpmd_pkg::REG_CHANNEL_COUNT, pick_channels());
    end else begin
      write_reg(wpmd_pkg::REG_SAMPLE_MODE, pick_mode());
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // full-scale s16, u8 and s24 samples and a minus-one s32 sample, from the reset setting
  task automatic test_pcm_extremes();
    send_sample(32'h0000_8000, 2, 1'b0);   // s16 most negative
    send_sample(32'h0000_7FFF, 2, 1'b1);   // s16 most positive, closes buffer
    drain_results(SETTLE_CYCLES);
    write_reg(wpmd_pkg::REG_SAMPLE_MODE, wpmd_pkg::MODE_U8);
    send_sample(32'h0000_0000, 1, 1'b0);
    send_sample(32'h0000_00FF, 1, 1'b1);
    drain_results(SETTLE_CYCLES);
    write_reg(wpmd_pkg::REG_SAMPLE_MODE, wpmd_pkg::MODE_S24);
    send_sample(32'h0080_0000, 3, 1'b1);
    drain_results(SETTLE_CYCLES);
    write_reg(wpmd_pkg::REG_SAMPLE_MODE, wpmd_pkg::MODE_S32);
    send_sample(32'hFFFF_FFFF, 4, 1'b1);   // lowest bit dropped toward minus inf
  endtask

  // non-finite float and an undefined mode both give a bad frame
  task automatic test_bad_samples();
    drain_results(SETTLE_CYCLES);
    write_reg(wpmd_pkg::REG_SAMPLE_MODE, wpmd_pkg::MODE_F32);
    send_sample(32'h7F80_0000, 4, 1'b0);
    drain_results(SETTLE_CYCLES);
    write_reg(wpmd_pkg::REG_SAMPLE_MODE, MODE_UNUSED_FIRST);
    send_item(8'h5A, 1'b0);
  endtask

  // partial frame at the end, then a channel count cut mid-frame
  task automatic test_frame_edges();
    drain_results(SETTLE_CYCLES);
    write_reg(wpmd_pkg::REG_SAMPLE_MODE, wpmd_pkg::MODE_U8);
    write_reg(wpmd_pkg::REG_CHANNEL_COUNT, 4'd3);
    send_item(8'h12, 1'b0);
    send_item(8'hC3, 1'b1);
    drain_results(SETTLE_CYCLES);
    write_reg(wpmd_pkg::REG_CHANNEL_COUNT, 4'd2);
    send_item(8'hFF, 1'b0);
    drain_results(SETTLE_CYCLES);
    // the open frame now completes at one channel, and its sum clamps
    write_reg(wpmd_pkg::REG_CHANNEL_COUNT, 4'd1);
    send_item(8'hFE, 1'b1);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    drain_results(SETTLE_CYCLES);
    write_reg(wpmd_pkg::REG_CHANNEL_COUNT, 4'd1);
    write_reg(wpmd_pkg::REG_SAMPLE_MODE, wpmd_pkg::MODE_U8);
    sender_gaps_on = 1'b0;
    hold_request   = HOLD_OFF_CYCLES;
    repeat (24) send_item(8'($urandom), 1'($urandom_range(0, 1)));
    sender_gaps_on = 1'b1;
    drain_results(SETTLE_CYCLES);
  endtask

  // random settings, mostly well-formed buffers, some cut short or left open
  task automatic test_random_traffic();
    int goal;
    int per_frame;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      drain_results(SETTLE_CYCLES);
      write_reg(wpmd_pkg::REG_CHANNEL_COUNT, pick_channels());
      write_reg(wpmd_pkg::REG_SAMPLE_MODE, pick_mode());
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0) run_unfinished();
        per_frame = frame_channels(cfg_channels) * mode_bytes(cfg_mode);
        run_buffer($urandom_range(1, (BUFFER_BYTES / per_frame > 1) ?
                                     BUFFER_BYTES / per_frame : 1),
                   $urandom_range(0, 4) == 0);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // receiver, checker and watchdog
  // ------------------------------------------------------------------------

  // ready changes at the falling edge, at most one assignment per edge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_request > 0) begin
        m_tready = 1'b0;
        repeat (hold_request - 1) @(negedge clk);
        hold_request = 0;
      end else begin
        if (rx_style_left <= 0) begin
          rx_style      = rx_style_t'($urandom_range(0, 3));
          rx_style_left = $urandom_range(20, 300);
        end
        rx_style_left--;
        case (rx_style)
          RX_OPEN:    m_tready = 1'b1;
          RX_COIN:    m_tready = 1'($urandom_range(0, 1));
          RX_PATTERN: m_tready = (rx_tick % 5) < 2;
          default: begin
            if (rx_chunk_left <= 0) begin
              rx_chunk_ready = ~rx_chunk_ready;
              rx_chunk_left  = $urandom_range(1, 40);
            end
            rx_chunk_left--;
            m_tready = rx_chunk_ready;
          end
        endcase
      end
    end
  end

  // every accepted result item against the oldest expectation
  always @(posedge clk) begin : check_results
    mono_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected result item: mono_sample %0d status %0d end_of_buffer %0b",
               $signed(m_tdata), m_tuser, m_tlast);
        mismatch_count++;
      end else begin
        want = pending_means.pop_front();
        if (m_tdata !== want.mono_sample) begin
          $error("mono_sample mismatch: expected %0d, got %0d",
                 $signed(want.mono_sample), $signed(m_tdata));
          mismatch_count++;
        end
        if (m_tuser !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
          mismatch_count++;
        end
        if (m_tlast !== want.end_of_buffer) begin
          $error("end_of_buffer mismatch: expected %0b, got %0b",
                 want.end_of_buffer, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // ends the run when neither side has moved an item for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = wpmd_pkg::REG_CHANNEL_COUNT;
    cfg_data  = '0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_pcm_extremes();
    test_bad_samples();
    test_frame_edges();
    test_output_backpressure();
    test_random_traffic();

    drain_results(END_CYCLES);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[wav_pcm_to_mono_downmix_top.f]
rtl/wpmd_pkg.sv
rtl/wav_pcm_to_mono_downmix_top.sv
bench/wav_pcm_to_mono_downmix_top_test.sv
